@@ rtl/tpsg_pkg.sv @@
// Package with shared types, constants and the quarter-wave sine table.
`default_nettype none

package tpsg_pkg;

  // Table geometry and sample format.
  localparam int unsigned TABLE_SIZE = 384;
  localparam int unsigned SINE_BITS  = 16;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);

  // Field and register widths.
  localparam int unsigned POS_W      = 9;
  localparam int unsigned CMP_W      = 16;
  localparam int unsigned DUTY_CFG_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Datapath widths: duty in Q1.23, span signed, product and biased sum.
  localparam int unsigned DUTY_W       = 24;
  localparam int unsigned SAMPLE_SHIFT = DUTY_W - SINE_BITS;
  localparam int unsigned FRAC_W       = 24;
  localparam int unsigned SPAN_W       = CMP_W + 1;
  localparam int unsigned PROD_W       = DUTY_W + SPAN_W;
  localparam int unsigned SUM_W        = PROD_W + 1;
  localparam int unsigned VAL_W        = SUM_W - FRAC_W;

  // Table offsets of phases B and C.
  localparam int unsigned OFFSET_B = ((TABLE_SIZE + 1) / 3) % TABLE_SIZE;
  localparam int unsigned OFFSET_C = ((2 * TABLE_SIZE + 1) / 3) % TABLE_SIZE;

  // Quarter-wave table: angles m = 0..TABLE_SIZE, only multiples of QSTEP occur.
  localparam int unsigned QSTEP_LOG  = (TABLE_SIZE % 4 == 0) ? 2 :
                                       ((TABLE_SIZE % 2 == 0) ? 1 : 0);
  localparam int unsigned QTAB_DEPTH = (TABLE_SIZE >> QSTEP_LOG) + 1;
  localparam int unsigned QIDX_W     = $clog2(QTAB_DEPTH);
  localparam int unsigned M_W        = $clog2(TABLE_SIZE + 1);

  // Constants of the fixed-point series.
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] AMP         = (64'd1 << (SINE_BITS - 1)) - 64'd1;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DUTY_UPPER   = 3'd0,
    CFG_DUTY_LOWER   = 3'd1,
    CFG_COMPARE_BIAS = 3'd2,
    CFG_COMPARE_CEIL = 3'd3,
    CFG_COMPARE_FLR  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [DUTY_CFG_W-1:0] duty_upper;
    logic signed [DUTY_CFG_W-1:0] duty_lower;
    logic        [CMP_W-1:0]      cmp_bias;
    logic        [CMP_W-1:0]      cmp_ceil;
    logic        [CMP_W-1:0]      cmp_flr;
  } cfg_t;

  // Input and result payloads.
  typedef struct packed {
    logic advance;
  } tick_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare_a;
    logic [CMP_W-1:0] compare_b;
    logic [CMP_W-1:0] compare_c;
    logic [POS_W-1:0] phase_position;
  } result_t;

  // Pipeline stage enables shared by the lanes.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // One write beat of the table loader.
  typedef struct packed {
    logic                 we;
    logic [IDX_W-1:0]     addr;
    logic [SINE_BITS-1:0] data;
  } fill_wr_t;

  typedef logic [SINE_BITS-2:0] qtab_t [QTAB_DEPTH];

  // Magnitude of sin(m/TABLE_SIZE * pi/2) scaled to AMP, Taylor series in Q2.30.
  function automatic logic [63:0] quarter_sine(input logic [63:0] m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (PI_HALF_Q30 * m) / 64'(TABLE_SIZE);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i-1];
      if ((i % 2) == 1) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * AMP + (64'd1 << 29)) >> 30;
    return (v > AMP) ? AMP : v;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int j = 0; j < QTAB_DEPTH; j++) begin
      t[j] = (SINE_BITS-1)'(quarter_sine(64'(j) << QSTEP_LOG));
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

endpackage

`default_nettype wire

@@ rtl/tpsg_if.sv @@
// Stream interfaces for the tick input and the compare result output.
`default_nettype none

interface tpsg_tick_if;
  import tpsg_pkg::*;

  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tpsg_result_if;
  import tpsg_pkg::*;

  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/tpsg_ram.sv @@
// Generic synchronous RAM with one write port and registered read ports.
`default_nettype none

module tpsg_ram #(
  parameter  int unsigned WIDTH    = 16,
  parameter  int unsigned DEPTH    = 384,
  parameter  int unsigned RD_PORTS = 2,
  localparam int unsigned AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i [RD_PORTS],
  output      logic [WIDTH-1:0] rdata_o [RD_PORTS]
);

  logic [WIDTH-1:0] mem_q   [DEPTH];
  logic [WIDTH-1:0] rdata_q [RD_PORTS];

  // Write and read; read data is held while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      for (int p = 0; p < RD_PORTS; p++) begin
        rdata_q[p] <= mem_q[raddr_i[p]];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/tpsg_rom_fill.sv @@
// Loader that writes the full sine table into the sample memories after reset.
`default_nettype none

module tpsg_rom_fill (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  output      tpsg_pkg::fill_wr_t  wr_o,
  output      logic                done_o
);
  import tpsg_pkg::*;

  logic [IDX_W-1:0]  k_q, k_d;
  logic [IDX_W-1:0]  r_q, r_d;
  logic [1:0]        quad_q, quad_d;
  logic              done_q, done_d;
  logic [IDX_W:0]    r_step;
  logic [M_W-1:0]    m;
  logic [QIDX_W-1:0] qidx;
  logic [SINE_BITS-1:0] mag;

  // Entry k sits at angle 4k in quarter units: r is 4k mod size, quad the quadrant.
  always_comb begin
    m      = quad_q[0] ? (M_W'(TABLE_SIZE) - M_W'(r_q)) : M_W'(r_q);
    qidx   = QIDX_W'(m >> QSTEP_LOG);
    mag    = {1'b0, QTAB[qidx]};
    r_step = (IDX_W+1)'(r_q) + (IDX_W+1)'(4);
  end

  // Advance the sweep one entry per cycle until the last entry is written.
  always_comb begin
    k_d    = k_q;
    r_d    = r_q;
    quad_d = quad_q;
    done_d = done_q;
    if (!done_q) begin
      k_d = k_q + IDX_W'(1);
      if (r_step >= (IDX_W+1)'(TABLE_SIZE)) begin
        r_d    = IDX_W'(r_step - (IDX_W+1)'(TABLE_SIZE));
        quad_d = quad_q + 2'd1;
      end else begin
        r_d = IDX_W'(r_step);
      end
      if (k_q == IDX_W'(TABLE_SIZE - 1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      r_q    <= '0;
      quad_q <= '0;
      done_q <= 1'b0;
    end else begin
      k_q    <= k_d;
      r_q    <= r_d;
      quad_q <= quad_d;
      done_q <= done_d;
    end
  end

  // The lower half of the wave is the negated upper half.
  assign wr_o.we   = !done_q;
  assign wr_o.addr = k_q;
  assign wr_o.data = quad_q[1] ? (-mag) : mag;
  assign done_o    = done_q;

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("table loader left the done state");

  a_end_quadrant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(quad_q) == 2'd3)
    else $error("table loader finished outside the last quadrant");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_q |-> r_q < IDX_W'(TABLE_SIZE))
    else $error("table loader angle remainder out of range");

endmodule

`default_nettype wire

@@ rtl/tpsg_lane.sv @@
// One phase lane: duty clamp, span multiply, bias, truncation and saturation.
`default_nettype none

module tpsg_lane (
  input  wire logic                              clk_i,
  input  wire tpsg_pkg::cfg_t                    cfg_i,
  input  wire tpsg_pkg::stage_en_t               en_i,
  input  wire logic signed [tpsg_pkg::SINE_BITS-1:0] sample_i,
  output      logic [tpsg_pkg::CMP_W-1:0]        cmp_o
);
  import tpsg_pkg::*;

  logic signed [DUTY_W-1:0] duty_raw;
  logic signed [DUTY_W-1:0] duty_hi;
  logic signed [DUTY_W-1:0] duty_lo;
  logic signed [DUTY_W-1:0] duty_d, duty_q;
  logic signed [SPAN_W-1:0] span;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_adj;
  logic signed [VAL_W-1:0]  val;
  logic        [CMP_W-1:0]  sat;
  logic        [CMP_W-1:0]  cmp_d, cmp_q;

  // Sample and clamps in Q1.23; the upper clamp is tested first.
  always_comb begin
    duty_raw = DUTY_W'(sample_i) <<< SAMPLE_SHIFT;
    duty_hi  = $signed({cfg_i.duty_upper, (DUTY_W-DUTY_CFG_W)'(0)});
    duty_lo  = $signed({cfg_i.duty_lower, (DUTY_W-DUTY_CFG_W)'(0)});
    priority if (duty_raw > duty_hi) begin
      duty_d = duty_hi;
    end else if (duty_raw < duty_lo) begin
      duty_d = duty_lo;
    end else begin
      duty_d = duty_raw;
    end
  end

  // Span may be negative when the floor lies above the ceiling.
  assign span   = $signed({1'b0, cfg_i.cmp_ceil}) - $signed({1'b0, cfg_i.cmp_flr});
  assign prod_d = duty_q * span;

  // Add the bias, truncate toward zero, then saturate to 16 bits and to the limits.
  always_comb begin
    sum     = SUM_W'(prod_q) + $signed(SUM_W'({cfg_i.cmp_bias, FRAC_W'(0)}));
    sum_adj = sum[SUM_W-1] ? (sum + $signed(SUM_W'({FRAC_W{1'b1}}))) : sum;
    val     = sum_adj[SUM_W-1:FRAC_W];
    priority if (val < 0) begin
      sat = '0;
    end else if (val > $signed(VAL_W'({CMP_W{1'b1}}))) begin
      sat = '1;
    end else begin
      sat = val[CMP_W-1:0];
    end
    priority if (sat > cfg_i.cmp_ceil) begin
      cmp_d = cfg_i.cmp_ceil;
    end else if (sat < cfg_i.cmp_flr) begin
      cmp_d = cfg_i.cmp_flr;
    end else begin
      cmp_d = sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      duty_q <= duty_d;
    end
    if (en_i.s3) begin
      prod_q <= prod_d;
    end
    if (en_i.s4) begin
      cmp_q <= cmp_d;
    end
  end

  assign cmp_o = cmp_q;

endmodule

`default_nettype wire

@@ rtl/three_phase_spwm_compare_gen.sv @@
// Top level of the three-phase sinusoidal PWM compare generator.
//
//   Port        Dir  Handshake      Beat contents
//   tick_i      in   valid/ready    advance
//   result_o    out  valid/ready    compare_a, compare_b, compare_c, phase_position
//   cfg_*_i     in   write enable   register index and 16-bit data
//
// One tick beat is accepted per cycle while the pipeline is not stalled; its result passes
// through four registers: the sample memory read, the duty clamp, the span multiply and the
// output stage.
// After reset the sine table is written into both sample memories, one entry per cycle,
// all 384 entries (TABLE_SIZE); tick_i.ready stays low until it is done.
// A stalled result holds in the output register; empty stages still take new beats.
`default_nettype none

module three_phase_spwm_compare_gen (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  tpsg_tick_if.sink                              tick_i,
  tpsg_result_if.source                          result_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tpsg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tpsg_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import tpsg_pkg::*;

  cfg_t               cfg_q, cfg_d;
  logic [IDX_W-1:0]   phase_q, phase_d;
  logic [IDX_W-1:0]   phase_next;
  logic [IDX_W:0]     sum_b, sum_c;
  logic [IDX_W-1:0]   addr_b, addr_c;
  logic               acc;
  stage_en_t          en;
  logic               v1_q, v2_q, v3_q, v4_q;
  logic [POS_W-1:0]   pos1_q, pos2_q, pos3_q, pos4_q;
  fill_wr_t           fill_wr;
  logic               fill_done;
  logic [IDX_W-1:0]   ram0_raddr [2];
  logic [SINE_BITS-1:0] ram0_rdata [2];
  logic [IDX_W-1:0]   ram1_raddr [1];
  logic [SINE_BITS-1:0] ram1_rdata [1];
  logic [CMP_W-1:0]   cmp_a, cmp_b, cmp_c;

  // Configuration registers; unknown indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DUTY_UPPER:   cfg_d.duty_upper = $signed(cfg_wdata_i);
        CFG_DUTY_LOWER:   cfg_d.duty_lower = $signed(cfg_wdata_i);
        CFG_COMPARE_BIAS: cfg_d.cmp_bias   = cfg_wdata_i;
        CFG_COMPARE_CEIL: cfg_d.cmp_ceil   = cfg_wdata_i;
        CFG_COMPARE_FLR:  cfg_d.cmp_flr    = cfg_wdata_i;
        default:          cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_upper <= 16'sh7FFF;
      cfg_q.duty_lower <= 16'sh8000;
      cfg_q.cmp_bias   <= 16'd1500;
      cfg_q.cmp_ceil   <= 16'd3000;
      cfg_q.cmp_flr    <= 16'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Stage enables: a stage moves when it is empty or the next one moves.
  always_comb begin
    en.s4 = !v4_q || result_o.ready;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign tick_i.ready = fill_done && en.s1;
  assign acc          = tick_i.valid && tick_i.ready;

  // Phase step with wrap, and the table addresses of the three phases.
  always_comb begin
    phase_next = phase_q;
    if (tick_i.data.advance) begin
      phase_next = (phase_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : phase_q + IDX_W'(1);
    end
    sum_b  = (IDX_W+1)'(phase_next) + (IDX_W+1)'(OFFSET_B);
    sum_c  = (IDX_W+1)'(phase_next) + (IDX_W+1)'(OFFSET_C);
    addr_b = (sum_b >= (IDX_W+1)'(TABLE_SIZE)) ?
             IDX_W'(sum_b - (IDX_W+1)'(TABLE_SIZE)) : IDX_W'(sum_b);
    addr_c = (sum_c >= (IDX_W+1)'(TABLE_SIZE)) ?
             IDX_W'(sum_c - (IDX_W+1)'(TABLE_SIZE)) : IDX_W'(sum_c);
    phase_d = acc ? phase_next : phase_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Table loader and the two copies of the sine table.
  tpsg_rom_fill u_fill (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_o   (fill_wr),
    .done_o (fill_done)
  );

  assign ram0_raddr[0] = phase_next;
  assign ram0_raddr[1] = addr_b;
  assign ram1_raddr[0] = addr_c;

  tpsg_ram #(
    .WIDTH    (SINE_BITS),
    .DEPTH    (TABLE_SIZE),
    .RD_PORTS (2)
  ) u_ram_ab (
    .clk_i   (clk_i),
    .we_i    (fill_wr.we),
    .waddr_i (fill_wr.addr),
    .wdata_i (fill_wr.data),
    .re_i    (en.s1),
    .raddr_i (ram0_raddr),
    .rdata_o (ram0_rdata)
  );

  tpsg_ram #(
    .WIDTH    (SINE_BITS),
    .DEPTH    (TABLE_SIZE),
    .RD_PORTS (1)
  ) u_ram_c (
    .clk_i   (clk_i),
    .we_i    (fill_wr.we),
    .waddr_i (fill_wr.addr),
    .wdata_i (fill_wr.data),
    .re_i    (en.s1),
    .raddr_i (ram1_raddr),
    .rdata_o (ram1_rdata)
  );

  // Valid bits of the four stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= acc;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  // Phase position travels alongside the lanes.
  always_ff @(posedge clk_i) begin
    if (en.s1) pos1_q <= POS_W'(phase_next);
    if (en.s2) pos2_q <= pos1_q;
    if (en.s3) pos3_q <= pos2_q;
    if (en.s4) pos4_q <= pos3_q;
  end

  tpsg_lane u_lane_a (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .en_i     (en),
    .sample_i ($signed(ram0_rdata[0])),
    .cmp_o    (cmp_a)
  );

  tpsg_lane u_lane_b (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .en_i     (en),
    .sample_i ($signed(ram0_rdata[1])),
    .cmp_o    (cmp_b)
  );

  tpsg_lane u_lane_c (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .en_i     (en),
    .sample_i ($signed(ram1_rdata[0])),
    .cmp_o    (cmp_c)
  );

  assign result_o.valid               = v4_q;
  assign result_o.data.compare_a      = cmp_a;
  assign result_o.data.compare_b      = cmp_b;
  assign result_o.data.compare_c      = cmp_c;
  assign result_o.data.phase_position = pos4_q;

  a_no_accept_during_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_i.ready |-> fill_done)
    else $error("tick accepted before the sine table was loaded");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= IDX_W'(TABLE_SIZE - 1))
    else $error("phase index out of table range");

  a_hold_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !tick_i.data.advance) |=> phase_q == $past(phase_q))
    else $error("phase index moved on a tick without advance");

endmodule

`default_nettype wire

@@ tb/sv/tpsg_compare_checker.sv @@
// Checker for the three-phase compare generator: mirrors its state, predicts and compares beats.
module tpsg_compare_checker
  import tpsg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tpsg_tick_if                  tick_i,
  tpsg_result_if                result_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    errors_o,
  output int                    pending_o,
  output int                    checked_o
);

  localparam int unsigned     SAMPLES      = TABLE_SIZE;
  localparam int unsigned     LEAD_B       = ((SAMPLES + 1) / 3) % SAMPLES;
  localparam int unsigned     LEAD_C       = ((2 * SAMPLES + 1) / 3) % SAMPLES;
  localparam longint unsigned HALF_PI_Q30  = 64'd1686629713;
  localparam longint unsigned PEAK         = (64'd1 << (SINE_BITS - 1)) - 64'd1;
  localparam longint          TO_Q23       = 64'sd1 << (24 - SINE_BITS);
  localparam longint          CLAMP_TO_Q23 = 64'sd256;
  localparam longint          FRAC_ONE     = 64'sd1 << 24;
  localparam longint          CMP_MAX      = 64'sd65535;

  // Mirror of the sine table, the phase pointer and the limit registers.
  int          sine_samples [SAMPLES];
  int unsigned phase_pos;
  int          duty_hi;
  int          duty_lo;
  int          bias;
  int          ceiling;
  int          floor_val;

  // Predicted compare beats, oldest first.
  result_t compare_queue [$];

  // Magnitude of the sine over one quadrant: Taylor series in Q2.30, rounded to the peak.
  function automatic int quarter_mag(int unsigned m);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned scaled;
    ang    = (HALF_PI_Q30 * m) / SAMPLES;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = ang;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = (acc > term) ? acc - term : 64'd0;
      end else begin
        acc = acc + term;
      end
    end
    scaled = (acc * PEAK + (64'd1 << 29)) >> 30;
    return (scaled > PEAK) ? int'(PEAK) : int'(scaled);
  endfunction

  // Compare value for one table index under the current limits.
  function automatic logic [CMP_W-1:0] compare_at(int unsigned idx);
    longint duty;
    longint hi;
    longint lo;
    longint span;
    longint acc;
    longint val;
    duty = longint'(sine_samples[idx % SAMPLES]) * TO_Q23;
    hi   = longint'(duty_hi) * CLAMP_TO_Q23;
    lo   = longint'(duty_lo) * CLAMP_TO_Q23;
    span = longint'(ceiling) - longint'(floor_val);
    // The upper clamp wins when the limits are reversed.
    if (duty > hi) begin
      duty = hi;
    end else if (duty < lo) begin
      duty = lo;
    end
    acc = duty * span + longint'(bias) * FRAC_ONE;
    // Signed division truncates toward zero.
    val = acc / FRAC_ONE;
    if (val < 0) begin
      val = 0;
    end
    if (val > CMP_MAX) begin
      val = CMP_MAX;
    end
    // Ceiling is tested before floor, which matters when the floor lies above it.
    if (val > longint'(ceiling)) begin
      val = longint'(ceiling);
    end else if (val < longint'(floor_val)) begin
      val = longint'(floor_val);
    end
    return CMP_W'(val);
  endfunction

  task automatic check_field(input string name, input logic [CMP_W-1:0] want,
                             input logic [CMP_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors_o++;
    end
  endtask

  // Full-wave table built from the quadrant magnitude.
  initial begin
    int unsigned quad;
    int unsigned rem;
    int unsigned m;
    int          mag;
    for (int k = 0; k < SAMPLES; k++) begin
      quad = (4 * k) / SAMPLES;
      rem  = (4 * k) % SAMPLES;
      m    = (quad % 2 == 1) ? SAMPLES - rem : rem;
      mag  = quarter_mag(m);
      sine_samples[k] = (quad >= 2) ? -mag : mag;
    end
  end

  // Watch the beats at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      phase_pos = 0;
      duty_hi   = 32767;
      duty_lo   = -32768;
      bias      = 1500;
      ceiling   = 3000;
      floor_val = 0;
      compare_queue.delete();
      errors_o  = 0;
      checked_o = 0;
    end else begin
      // Result beat: compare with the oldest prediction.
      if (result_i.valid && result_i.ready) begin
        got = result_i.data;
        if (compare_queue.size() == 0) begin
          $error("result beat with no prediction pending: %p", got);
          errors_o++;
        end else begin
          want = compare_queue.pop_front();
          checked_o++;
          check_field("compare_a", want.compare_a, got.compare_a);
          check_field("compare_b", want.compare_b, got.compare_b);
          check_field("compare_c", want.compare_c, got.compare_c);
          check_field("phase_position", CMP_W'(want.phase_position),
                      CMP_W'(got.phase_position));
        end
      end

      // Register writes; unused indexes leave every limit alone.
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DUTY_UPPER:   duty_hi   = int'(signed'(cfg_wdata_i));
          CFG_DUTY_LOWER:   duty_lo   = int'(signed'(cfg_wdata_i));
          CFG_COMPARE_BIAS: bias      = int'(cfg_wdata_i);
          CFG_COMPARE_CEIL: ceiling   = int'(cfg_wdata_i);
          CFG_COMPARE_FLR:  floor_val = int'(cfg_wdata_i);
          default: ;
        endcase
      end

      // Tick beat: step the phase if asked, then predict all three phases.
      if (tick_i.valid && tick_i.ready) begin
        if (tick_i.data.advance) begin
          phase_pos = (phase_pos + 1 == SAMPLES) ? 0 : phase_pos + 1;
        end
        want.compare_a      = compare_at(phase_pos);
        want.compare_b      = compare_at(phase_pos + LEAD_B);
        want.compare_c      = compare_at(phase_pos + LEAD_C);
        want.phase_position = POS_W'(phase_pos);
        compare_queue.push_back(want);
      end
    end
    pending_o = compare_queue.size();
  end

endmodule

@@ tb/sv/tb_three_phase_spwm_compare_gen.sv @@
// Testbench top for the three-phase compare generator: clock, reset, stimulus and verdict.
module tb_three_phase_spwm_compare_gen;
  import tpsg_pkg::*;

  localparam int          RESET_CYCLES     = 12;
  localparam int          SETTLE_CYCLES    = 8;
  localparam int          LONG_HOLD        = 300;
  localparam int          WATCHDOG_LIMIT   = 3000;
  localparam int          RANDOM_SETS      = 9;
  localparam int          PRESSURE_SET     = 1;
  localparam int unsigned FIRST_UNUSED_IDX = CFG_COMPARE_FLR + 1;
  localparam int unsigned UNUSED_COUNT     = (1 << CFG_IDX_W) - FIRST_UNUSED_IDX;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int errors;
  int pending;
  int checked;
  int ticks_sent;
  int limit_sets;
  int idle_cycles = 0;
  bit tx_gaps;
  bit rx_gaps;
  bit hold_req;

  tpsg_tick_if   tick_ch ();
  tpsg_result_if result_ch ();

  three_phase_spwm_compare_gen dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_ch),
    .result_o    (result_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tpsg_compare_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick_ch),
    .result_i    (result_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // 20-unit clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int draw_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 40);
    end
  endfunction

  function automatic int tx_gap();
    return tx_gaps ? draw_gap() : 0;
  endfunction

  // Register word with a bias toward the extremes.
  function automatic logic [CFG_DATA_W-1:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h7FFF;
      3:       return 16'h8000;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // One register write; the write enable stays high for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk_i);
  endtask

  // Write all five limits, then some writes to unused indexes that must be ignored.
  task automatic program_limits(input logic [CFG_DATA_W-1:0] upper,
                                input logic [CFG_DATA_W-1:0] lower,
                                input logic [CFG_DATA_W-1:0] bias,
                                input logic [CFG_DATA_W-1:0] ceiling,
                                input logic [CFG_DATA_W-1:0] floor_val,
                                input int                    unused_writes);
    int start;
    start = $urandom_range(0, UNUSED_COUNT - 1);
    write_reg(CFG_DUTY_UPPER, upper);
    write_reg(CFG_DUTY_LOWER, lower);
    write_reg(CFG_COMPARE_BIAS, bias);
    write_reg(CFG_COMPARE_CEIL, ceiling);
    write_reg(CFG_COMPARE_FLR, floor_val);
    for (int i = 0; i < unused_writes; i++) begin
      write_reg(CFG_IDX_W'(FIRST_UNUSED_IDX + (start + i) % UNUSED_COUNT),
                CFG_DATA_W'($urandom));
    end
    cfg_we <= 1'b0;
    limit_sets++;
  endtask

  // Offer one tick beat after a gap and hold it until it is taken.
  task automatic send_tick(input logic adv, input int gap);
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid        <= 1'b1;
    tick_ch.data.advance <= adv;
    @(posedge clk_i);
    while (!tick_ch.ready) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
    ticks_sent++;
  endtask

  // Stop offering and wait until every predicted beat has come out.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Result receiver: random stalls, or one long hold-off on request.
  initial begin
    int stall_left;
    int g;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        g = rx_gaps ? draw_gap() : 0;
        result_ch.ready <= (g == 0);
        stall_left = (g > 0) ? g - 1 : 0;
      end
    end
  end

  // Stimulus: directed corners first, then random limit sets with random tick streams.
  initial begin
    logic [CFG_DATA_W-1:0] upper;
    logic [CFG_DATA_W-1:0] lower;
    logic [CFG_DATA_W-1:0] bias;
    logic [CFG_DATA_W-1:0] ceiling;
    logic [CFG_DATA_W-1:0] floor_val;
    int                    burst;
    int                    adv_pct;

    tick_ch.valid = 1'b0;
    tick_ch.data  = '0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_DUTY_UPPER;
    cfg_wdata     = '0;
    tx_gaps       = 1'b1;
    rx_gaps       = 1'b1;
    hold_req      = 1'b0;
    ticks_sent    = 0;
    limit_sets    = 0;
    rst_ni        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset limits: hold at zero, step twice, hold again.
    send_tick(1'b0, tx_gap());
    send_tick(1'b1, tx_gap());
    send_tick(1'b1, tx_gap());
    send_tick(1'b0, tx_gap());
    drain();

    // Reversed duty clamps.
    program_limits(16'hC000, 16'h4000, 16'h8000, 16'hFFFF, 16'h0000, 0);
    for (int i = 0; i < 3; i++) begin
      send_tick(i != 2, tx_gap());
    end
    drain();

    // Full duty range with the bias at the top: sums run past the 16-bit range.
    program_limits(16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000, 0);
    for (int i = 0; i < 3; i++) begin
      send_tick(i != 2, tx_gap());
    end
    drain();

    // Bias at zero: negative duty drives sums below zero.
    program_limits(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0000, 0);
    for (int i = 0; i < 3; i++) begin
      send_tick(1'b1, tx_gap());
    end
    drain();

    // Floor above the ceiling: negative span.
    program_limits(16'h7FFF, 16'h8000, 16'd30000, 16'd1000, 16'd60000, 0);
    for (int i = 0; i < 3; i++) begin
      send_tick(i != 1, tx_gap());
    end
    drain();

    // All limits zero, then every unused index written.
    program_limits(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, UNUSED_COUNT);
    for (int i = 0; i < 3; i++) begin
      send_tick(1'b1, tx_gap());
    end
    drain();

    // Random limit sets, most of them well formed.
    for (int s = 0; s < RANDOM_SETS; s++) begin
      if ($urandom_range(0, 99) < 65) begin
        floor_val = CFG_DATA_W'($urandom_range(0, 40000));
        ceiling   = CFG_DATA_W'($urandom_range(floor_val, 65535));
        bias      = CFG_DATA_W'($urandom_range(floor_val, ceiling));
        upper     = CFG_DATA_W'($urandom_range(0, 32767));
        lower     = CFG_DATA_W'(-int'($urandom_range(0, 32768)));
      end else begin
        upper     = draw_word();
        lower     = draw_word();
        bias      = draw_word();
        ceiling   = draw_word();
        floor_val = draw_word();
      end
      program_limits(upper, lower, bias, ceiling, floor_val, ($urandom_range(0, 9) == 0));

      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      // One set keeps offering ticks while the receiver holds off for a long stretch.
      if (s == PRESSURE_SET) begin
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
      end
      burst   = $urandom_range(80, 120);
      adv_pct = $urandom_range(50, 100);
      repeat (burst) begin
        send_tick($urandom_range(0, 99) < adv_pct, tx_gap());
      end
      drain();
    end

    $display("Summary: %0d tick beats sent, %0d results checked over %0d limit sets,",
             ticks_sent, checked, limit_sets);
    $display("  with reversed clamps, an inverted compare range, saturation, unused indexes");
    $display("  and a long output hold.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: ends the run when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no beat accepted for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
rtl/tpsg_pkg.sv
rtl/tpsg_if.sv
rtl/tpsg_ram.sv
rtl/tpsg_rom_fill.sv
rtl/tpsg_lane.sv
rtl/three_phase_spwm_compare_gen.sv
tb/sv/tpsg_compare_checker.sv
tb/sv/tb_three_phase_spwm_compare_gen.sv
